// ===== rtl/core/imucss_pkg.sv =====
// Shared constants, types and register codes for the IMU channel smoother.
package imucss_pkg;

    // Sizing
    localparam int CHANNELS     = 6;
    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 24;
    localparam int CH_BITS      = 3;
    localparam int W_BITS       = FRAC_BITS + 1;
    localparam int ACC_BITS     = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int CFG_IDX_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FAST_WEIGHT = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_WEIGHT = CFG_IDX_BITS'(1);

    // Weight reset values: 0.5 and about 0.0002
    localparam logic [W_BITS-1:0] FAST_W_RESET = W_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [W_BITS-1:0] SLOW_W_RESET =
        W_BITS'(longint'(0.0002 * (2.0 ** FRAC_BITS)));

    // Weight of exactly one
    localparam logic [W_BITS-1:0] ONE_W = W_BITS'(1) << FRAC_BITS;

    typedef logic signed [ACC_BITS-1:0] t_acc;

    typedef struct packed {
        logic [CH_BITS-1:0]            channel;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          restart;
    } t_item;

    typedef struct packed {
        logic  vld;
        t_item item;
    } t_upd;

    typedef struct packed {
        logic [W_BITS-1:0] fast;
        logic [W_BITS-1:0] slow;
    } t_weights;

    typedef struct packed {
        logic [CH_BITS-1:0]            channel_out;
        logic signed [SAMPLE_BITS-1:0] fast_average;
        logic signed [SAMPLE_BITS-1:0] slow_average;
        logic signed [SAMPLE_BITS-1:0] lowest_fast;
        logic signed [SAMPLE_BITS-1:0] highest_fast;
    } t_result;

endpackage

// ===== rtl/core/imucss_if.sv =====
// Valid/ready channel interfaces: sample input, statistics output, register writes.
interface imucss_in_if;
    logic                                       valid;
    logic                                       ready;
    logic [imucss_pkg::CH_BITS-1:0]             channel;
    logic signed [imucss_pkg::SAMPLE_BITS-1:0]  sample;
    logic                                       restart;

    modport source (output valid, output channel, output sample, output restart, input ready);
    modport sink   (input valid, input channel, input sample, input restart, output ready);
endinterface

interface imucss_out_if;
    logic                                       valid;
    logic                                       ready;
    logic [imucss_pkg::CH_BITS-1:0]             channel_out;
    logic signed [imucss_pkg::SAMPLE_BITS-1:0]  fast_average;
    logic signed [imucss_pkg::SAMPLE_BITS-1:0]  slow_average;
    logic signed [imucss_pkg::SAMPLE_BITS-1:0]  lowest_fast;
    logic signed [imucss_pkg::SAMPLE_BITS-1:0]  highest_fast;

    modport source (output valid, output channel_out, output fast_average,
                    output slow_average, output lowest_fast, output highest_fast,
                    input ready);
    modport sink   (input valid, input channel_out, input fast_average,
                    input slow_average, input lowest_fast, input highest_fast,
                    output ready);
endinterface

interface imucss_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [imucss_pkg::CFG_IDX_BITS-1:0]     index;
    logic [imucss_pkg::W_BITS-1:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/imucss_ema.sv =====
// One exponential average step: acc + floor(w * (x * 2^F - acc) / 2^F).
module imucss_ema (
    input  imucss_pkg::t_acc                          i_acc,
    input  logic signed [imucss_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [imucss_pkg::W_BITS-1:0]             i_weight,
    output imucss_pkg::t_acc                          o_acc
);
    import imucss_pkg::*;

    localparam int DIFF_BITS = ACC_BITS + 1;
    localparam int DH_BITS   = DIFF_BITS - FRAC_BITS;
    localparam int HI_BITS   = DH_BITS + W_BITS + 1;
    localparam int LO_BITS   = FRAC_BITS + W_BITS;

    logic [W_BITS-1:0]            w_eff;
    t_acc                         target;
    logic signed [DIFF_BITS-1:0]  diff;
    logic signed [DH_BITS-1:0]    diff_hi;
    logic [FRAC_BITS-1:0]         diff_lo;
    logic signed [W_BITS:0]       w_signed;
    logic signed [HI_BITS-1:0]    hi_prod;
    logic [LO_BITS-1:0]           lo_prod;
    logic signed [HI_BITS-1:0]    step;

    // Weights above one act as exactly one
    assign w_eff    = (i_weight > ONE_W) ? ONE_W : i_weight;
    assign w_signed = $signed({1'b0, w_eff});

    // Distance from the accumulator to the sample in Q.F
    assign target = ACC_BITS'($signed({i_sample, {FRAC_BITS{1'b0}}}));
    assign diff   = DIFF_BITS'(target) - DIFF_BITS'(i_acc);

    // Split the distance so each partial product stays narrow:
    // diff = diff_hi * 2^F + diff_lo, diff_lo unsigned. Floor of the
    // scaled product is then hi product plus floor of the low part.
    assign diff_hi = diff[DIFF_BITS-1:FRAC_BITS];
    assign diff_lo = diff[FRAC_BITS-1:0];
    assign hi_prod = diff_hi * w_signed;
    assign lo_prod = diff_lo * w_eff;
    assign step    = hi_prod + HI_BITS'($signed({1'b0, lo_prod[LO_BITS-1:FRAC_BITS]}));

    // The step never leaves the span between accumulator and sample
    assign o_acc = i_acc + ACC_BITS'(step);

endmodule

// ===== rtl/core/imucss_chan_state.sv =====
// Per-channel averages, min/max and load flags, updated by one word per cycle.
module imucss_chan_state (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  imucss_pkg::t_upd      i_upd,
    input  imucss_pkg::t_weights  i_weights,
    output imucss_pkg::t_result   o_res
);
    import imucss_pkg::*;

    t_acc                          r_fast [CHANNELS];
    t_acc                          r_slow [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_low  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_high [CHANNELS];
    logic [CHANNELS-1:0]           r_primed;

    logic                          in_range;
    logic                          do_load;
    logic [CH_BITS-1:0]            ch;
    t_acc                          cur_fast;
    t_acc                          cur_slow;
    logic signed [SAMPLE_BITS-1:0] cur_low;
    logic signed [SAMPLE_BITS-1:0] cur_high;
    t_acc                          upd_fast;
    t_acc                          upd_slow;
    t_acc                          n_fast;
    t_acc                          n_slow;
    logic signed [SAMPLE_BITS-1:0] n_low;
    logic signed [SAMPLE_BITS-1:0] n_high;
    logic signed [SAMPLE_BITS-1:0] fast_floor;
    t_acc                          load_acc;

    assign ch       = i_upd.item.channel;
    assign in_range = int'(ch) < CHANNELS;

    // Read the addressed channel; out-of-range reads as zero
    always_comb begin
        cur_fast = '0;
        cur_slow = '0;
        cur_low  = '0;
        cur_high = '0;
        do_load  = 1'b1;
        if (in_range) begin
            cur_fast = r_fast[ch];
            cur_slow = r_slow[ch];
            cur_low  = r_low[ch];
            cur_high = r_high[ch];
            do_load  = i_upd.item.restart || !r_primed[ch];
        end
    end

    imucss_ema u_fast_ema (
        .i_acc    (cur_fast),
        .i_sample (i_upd.item.sample),
        .i_weight (i_weights.fast),
        .o_acc    (upd_fast)
    );

    imucss_ema u_slow_ema (
        .i_acc    (cur_slow),
        .i_sample (i_upd.item.sample),
        .i_weight (i_weights.slow),
        .o_acc    (upd_slow)
    );

    // Load or update, then fold the fast floor into min/max
    assign load_acc   = ACC_BITS'($signed({i_upd.item.sample, {FRAC_BITS{1'b0}}}));
    assign fast_floor = upd_fast[FRAC_BITS +: SAMPLE_BITS];

    always_comb begin
        if (do_load) begin
            n_fast = load_acc;
            n_slow = load_acc;
            n_low  = i_upd.item.sample;
            n_high = i_upd.item.sample;
        end else begin
            n_fast = upd_fast;
            n_slow = upd_slow;
            n_low  = (fast_floor < cur_low)  ? fast_floor : cur_low;
            n_high = (fast_floor > cur_high) ? fast_floor : cur_high;
        end
    end

    // Result word
    always_comb begin
        o_res             = '0;
        o_res.channel_out = ch;
        if (in_range) begin
            o_res.fast_average = n_fast[FRAC_BITS +: SAMPLE_BITS];
            o_res.slow_average = n_slow[FRAC_BITS +: SAMPLE_BITS];
            o_res.lowest_fast  = n_low;
            o_res.highest_fast = n_high;
        end
    end

    // Load flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= '0;
        end else if (i_upd.vld && in_range) begin
            r_primed[ch] <= 1'b1;
        end
    end

    // Channel statistics
    always_ff @(posedge i_clk) begin
        if (i_upd.vld && in_range) begin
            r_fast[ch] <= n_fast;
            r_slow[ch] <= n_slow;
            r_low[ch]  <= n_low;
            r_high[ch] <= n_high;
        end
    end

    a_primed_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd.vld && in_range) |=> r_primed[$past(ch)])
        else $error("channel not marked loaded after update");

    a_bad_channel_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd.vld && !in_range) |=> (r_primed == $past(r_primed)))
        else $error("out-of-range channel changed load flags");

    a_fast_within_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd.vld && in_range) |->
            (o_res.lowest_fast <= o_res.fast_average &&
             o_res.fast_average <= o_res.highest_fast))
        else $error("fast average outside its min/max");

endmodule

// ===== rtl/core/imucss_cfg_regs.sv =====
// Weight registers written through the configuration channel.
module imucss_cfg_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    imucss_cfg_if.sink           i_cfg,
    output imucss_pkg::t_weights o_weights
);
    import imucss_pkg::*;

    t_weights r_weights;
    t_weights n_weights;

    assign i_cfg.ready = 1'b1;
    assign o_weights   = r_weights;

    // Decode the write; unknown indexes are dropped
    always_comb begin
        n_weights = r_weights;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FAST_WEIGHT: n_weights.fast = i_cfg.data;
                REG_SLOW_WEIGHT: n_weights.slow = i_cfg.data;
                default:         n_weights = r_weights;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights.fast <= FAST_W_RESET;
            r_weights.slow <= SLOW_W_RESET;
        end else begin
            r_weights <= n_weights;
        end
    end

endmodule

// ===== rtl/core/imu_channel_smoother_stats.sv =====
// Sample words pass through the input register, results through the result register.
// Throughput: one word per cycle while the output is not stalled, any mix of channels;
//   the channel state is read, updated and written back in the input-to-result step.
// Reset (synchronous, active low): both stages empty, all channels unloaded, weights
//   back to 0.5 (fast) and about 0.0002 (slow). No clearing pass is needed.
module imu_channel_smoother_stats (
    input  logic         i_clk,
    input  logic         i_rst_n,
    imucss_in_if.sink    i_in,
    imucss_out_if.source o_out,
    imucss_cfg_if.sink   i_cfg
);
    import imucss_pkg::*;

    logic     r_in_vld;
    logic     n_in_vld;
    t_item    r_in;
    logic     r_out_vld;
    logic     n_out_vld;
    t_result  r_res;
    logic     advance;
    logic     in_take;
    t_upd     upd;
    t_weights weights;
    t_result  res;

    imucss_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_weights (weights)
    );

    // Handshake: result register frees up when empty or taken
    assign advance    = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_in_vld || advance;
    assign in_take    = i_in.valid && i_in.ready;

    assign upd.vld  = r_in_vld && advance;
    assign upd.item = r_in;

    imucss_chan_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (upd),
        .i_weights (weights),
        .o_res     (res)
    );

    // Stage valids
    always_comb begin
        n_in_vld  = r_in_vld;
        n_out_vld = r_out_vld;
        if (in_take) begin
            n_in_vld = 1'b1;
        end else if (advance) begin
            n_in_vld = 1'b0;
        end
        if (advance) begin
            n_out_vld = r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.channel <= i_in.channel;
            r_in.sample  <= i_in.sample;
            r_in.restart <= i_in.restart;
        end
        if (upd.vld) begin
            r_res <= res;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.channel_out  = r_res.channel_out;
    assign o_out.fast_average = r_res.fast_average;
    assign o_out.slow_average = r_res.slow_average;
    assign o_out.lowest_fast  = r_res.lowest_fast;
    assign o_out.highest_fast = r_res.highest_fast;

    a_word_kept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !o_out.ready) |=> r_in_vld)
        else $error("input word dropped while output stalled");

    a_result_follows_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && advance) |=> r_out_vld)
        else $error("processed word produced no result");

    a_no_result_from_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_vld && advance) |=> !r_out_vld)
        else $error("result appeared without an input word");

endmodule
